/* rtl/psw_pkg.sv */
// Shared types and constants for the position weight matrix window scanner.
// Used by psw_cell and pssm_window_scan; depends on nothing else.
package psw_pkg;

  // Default sizes handed down as module parameters.
  localparam int MAX_MOTIF_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the block's ports.
  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int COL_W    = 2;
  localparam int WIN_W    = 16;
  localparam int CODE_W   = 3;
  localparam int SCORE_W  = 21;
  localparam int ADDR_W   = 32;
  localparam int MLEN_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Command codes of an input word.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REGION = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCORE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION    = 2'd2;

  // Base symbol codes: A, C, G, T are the only known symbols.
  localparam logic [CODE_W-1:0] CODE_A = 3'd1;
  localparam logic [CODE_W-1:0] CODE_T = 3'd4;

  // Score limits and the sentinel for a window holding an unknown symbol.
  localparam int SCORE_MAX = 1048575;
  localparam int SCORE_MIN = -1048576;
  localparam logic signed [SCORE_W-1:0] UNKNOWN_SCORE = -21'sd256000;

  // Control group broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;    // start of a new region: empty the window
    logic shift;    // push a new base into the window
    logic capture;  // copy the window into the evaluation row
    logic align;    // move the evaluation row down by one cell
  } psw_ctl_t;

endpackage

/* rtl/pssm_window_scan.sv */
// Top level of the position weight matrix window scanner: configuration
// registers, sequencer, output register and the row of psw_cell instances.
// Uses psw_pkg.
//
// Usage: words enter on the in_ channel (valid/ready). A load word stores a
// signed weight for one motif position and base column, a region word
// empties the window and restarts the coordinate count, a score word pushes
// one base code into the window. Once the window of motif_len bases is full,
// each score word yields one result word on the out_ channel: start
// coordinate, saturated score (or the unknown sentinel), hit flag and
// unknown flag. Configuration registers are written over the cfg_ channel,
// which is always ready.
// Load, region and score words that give no result leave the input ready.
// A score word that gives a result holds the input while the sequencer
// captures the window into the evaluation row, moves the row down by one
// cell per alignment step until motif position 0 sits in cell 0, and lets
// the sum chain ripple through all MAX_MOTIF cells.
// The result then waits in an output register; further words are accepted
// while it waits, and only the next scoring result is held until out_ready.
// Reset empties the window, clears the counters and sets motif_len to 1;
// weights hold no value until loaded.
module pssm_window_scan #(
  parameter int MAX_MOTIF   = psw_pkg::MAX_MOTIF_DEF,
  parameter int WEIGHT_BITS = psw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [psw_pkg::CMD_W-1:0]             in_command,
  input  logic [psw_pkg::POS_W-1:0]             in_weight_position,
  input  logic [psw_pkg::COL_W-1:0]             in_weight_base,
  input  logic signed [psw_pkg::WIN_W-1:0]      in_weight_value,
  input  logic [psw_pkg::CODE_W-1:0]            in_base_code,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [psw_pkg::ADDR_W-1:0]            out_window_start,
  output logic signed [psw_pkg::SCORE_W-1:0]    out_window_score,
  output logic                                  out_is_hit,
  output logic                                  out_has_unknown,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psw_pkg::CFG_DAT_W-1:0]         cfg_data
);
  import psw_pkg::*;

  localparam int LEN_W  = $clog2(MAX_MOTIF + 1);
  localparam int CMP_W  = (LEN_W > MLEN_W) ? LEN_W : MLEN_W;
  localparam int SUM_W0 = WEIGHT_BITS + $clog2(MAX_MOTIF) + 1;
  localparam int SUM_W  = (SUM_W0 > SCORE_W + 1) ? SUM_W0 : SCORE_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SCORE_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(SCORE_MIN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPT,
    ST_ALIGN,
    ST_SUM,
    ST_DONE
  } state_t;

  // Configuration registers.
  logic [MLEN_W-1:0]         motif_len_r;
  logic signed [SCORE_W-1:0] threshold_r;
  logic [ADDR_W-1:0]         region_base_r;

  // Sequencer and counters.
  state_t               state_r, state_nxt;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [LEN_W-1:0]     fill_r, fill_nxt;
  logic [ADDR_W-1:0]    seen_r, seen_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]         start_r, start_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic                      hit_r, hit_nxt;
  logic                      unk_r, unk_nxt;

  logic                      in_acc;
  logic                      cfg_acc;
  logic [LEN_W-1:0]          len;
  logic [CMP_W-1:0]          ml_ext;
  logic [LEN_W-1:0]          align_cnt;
  logic signed [WEIGHT_BITS-1:0] load_val;
  logic signed [SUM_W-1:0]   sum_top;
  logic                      unk_top;
  logic signed [SCORE_W-1:0] score_fin;
  psw_ctl_t                  ctl;

  logic [CODE_W-1:0]         base_link [MAX_MOTIF];
  logic [CODE_W-1:0]         eval_link [MAX_MOTIF];
  logic signed [SUM_W-1:0]   sum_link  [MAX_MOTIF];
  logic                      unk_link  [MAX_MOTIF];

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motif_len_r   <= MLEN_W'(1);
      threshold_r   <= '0;
      region_base_r <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_MOTIF_LEN: motif_len_r   <= cfg_data[MLEN_W-1:0];
        REG_THRESHOLD: threshold_r   <= cfg_data[SCORE_W-1:0];
        REG_REGION:    region_base_r <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Window length in use: zero acts as one, anything above the row as the row.
  assign ml_ext = CMP_W'(motif_len_r);
  always_comb begin
    if (motif_len_r == '0) begin
      len = LEN_W'(1);
    end else if (ml_ext > CMP_W'(MAX_MOTIF)) begin
      len = LEN_W'(MAX_MOTIF);
    end else begin
      len = LEN_W'(ml_ext);
    end
  end

  // The window is kept with its newest base in the top cell, so position 0
  // of the motif sits MAX_MOTIF - len cells above cell 0.
  assign align_cnt = LEN_W'(MAX_MOTIF) - len;

  // Loaded weights saturate to the stored width.
  generate
    if (WEIGHT_BITS >= WIN_W) begin : g_wide
      assign load_val = WEIGHT_BITS'(in_weight_value);
    end else begin : g_narrow
      localparam logic signed [WIN_W-1:0] W_HI = WIN_W'(2 ** (WEIGHT_BITS - 1) - 1);
      localparam logic signed [WIN_W-1:0] W_LO = WIN_W'(-(2 ** (WEIGHT_BITS - 1)));
      logic signed [WIN_W-1:0] clipped;
      always_comb begin
        if (in_weight_value > W_HI) begin
          clipped = W_HI;
        end else if (in_weight_value < W_LO) begin
          clipped = W_LO;
        end else begin
          clipped = in_weight_value;
        end
      end
      assign load_val = clipped[WEIGHT_BITS-1:0];
    end
  endgenerate

  always_comb begin
    ctl.clear   = in_acc && (in_command == CMD_REGION);
    ctl.shift   = in_acc && (in_command == CMD_SCORE);
    ctl.capture = (state_r == ST_CAPT);
    ctl.align   = (state_r == ST_ALIGN);
  end

  // The row of cells.
  generate
    for (genvar k = 0; k < MAX_MOTIF; k++) begin : g_cell
      logic [CODE_W-1:0]       base_src;
      logic [CODE_W-1:0]       eval_src;
      logic signed [SUM_W-1:0] sum_src;
      logic                    unk_src;
      logic                    wr_en;
      logic                    in_use;

      if (k == MAX_MOTIF - 1) begin : g_top
        assign base_src = in_base_code;
        assign eval_src = '0;
      end else begin : g_mid
        assign base_src = base_link[k+1];
        assign eval_src = eval_link[k+1];
      end

      if (k == 0) begin : g_first
        assign sum_src = '0;
        assign unk_src = 1'b0;
      end else begin : g_rest
        assign sum_src = sum_link[k-1];
        assign unk_src = unk_link[k-1];
      end

      assign wr_en  = in_acc && (in_command == CMD_LOAD) &&
                      (int'(in_weight_position) == k);
      assign in_use = LEN_W'(k) < len;

      psw_cell #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .SUM_W       (SUM_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .base_in  (base_src),
        .base_out (base_link[k]),
        .eval_in  (eval_src),
        .eval_out (eval_link[k]),
        .wr_en    (wr_en),
        .wr_col   (in_weight_base),
        .wr_val   (load_val),
        .in_use   (in_use),
        .sum_in   (sum_src),
        .unk_in   (unk_src),
        .sum_out  (sum_link[k]),
        .unk_out  (unk_link[k])
      );
    end
  endgenerate

  assign sum_top = sum_link[MAX_MOTIF-1];
  assign unk_top = unk_link[MAX_MOTIF-1];

  always_comb begin
    if (unk_top) begin
      score_fin = UNKNOWN_SCORE;
    end else if (sum_top > SUM_HI) begin
      score_fin = SUM_HI[SCORE_W-1:0];
    end else if (sum_top < SUM_LO) begin
      score_fin = SUM_LO[SCORE_W-1:0];
    end else begin
      score_fin = sum_top[SCORE_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    start_nxt     = start_r;
    score_nxt     = score_r;
    hit_nxt       = hit_r;
    unk_nxt       = unk_r;

    if (ctl.clear) begin
      fill_nxt = '0;
      seen_nxt = '0;
    end

    case (state_r)
      ST_IDLE: begin
        if (ctl.shift) begin
          seen_nxt = seen_r + ADDR_W'(1);
          if (fill_r < LEN_W'(MAX_MOTIF)) begin
            fill_nxt = fill_r + LEN_W'(1);
          end
          if (fill_nxt >= len) begin
            state_nxt = ST_CAPT;
          end
        end
      end
      ST_CAPT: begin
        if (align_cnt == '0) begin
          state_nxt = ST_SUM;
          cnt_nxt   = LEN_W'(MAX_MOTIF);
        end else begin
          state_nxt = ST_ALIGN;
          cnt_nxt   = align_cnt;
        end
      end
      ST_ALIGN: begin
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = ST_SUM;
          cnt_nxt   = LEN_W'(MAX_MOTIF);
        end else begin
          cnt_nxt = cnt_r - LEN_W'(1);
        end
      end
      ST_SUM: begin
        if (cnt_r == LEN_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - LEN_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          start_nxt     = region_base_r + seen_r - ADDR_W'(len);
          score_nxt     = score_fin;
          hit_nxt       = score_fin > threshold_r;
          unk_nxt       = unk_top;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r <= start_nxt;
    score_r <= score_nxt;
    hit_r   <= hit_nxt;
    unk_r   <= unk_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_window_start = start_r;
  assign out_window_score = score_r;
  assign out_is_hit       = hit_r;
  assign out_has_unknown  = unk_r;

endmodule

/* rtl/psw_cell.sv */
// One motif position of the scanner: a window entry, four weights, an
// evaluation slot and one stage of the running score sum. Uses psw_pkg.
module psw_cell #(
  parameter int WEIGHT_BITS = psw_pkg::WEIGHT_BITS_DEF,
  parameter int SUM_W       = 22
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  psw_pkg::psw_ctl_t                    ctl,
  input  logic [psw_pkg::CODE_W-1:0]           base_in,
  output logic [psw_pkg::CODE_W-1:0]           base_out,
  input  logic [psw_pkg::CODE_W-1:0]           eval_in,
  output logic [psw_pkg::CODE_W-1:0]           eval_out,
  input  logic                                 wr_en,
  input  logic [psw_pkg::COL_W-1:0]            wr_col,
  input  logic signed [WEIGHT_BITS-1:0]        wr_val,
  input  logic                                 in_use,
  input  logic signed [SUM_W-1:0]              sum_in,
  input  logic                                 unk_in,
  output logic signed [SUM_W-1:0]              sum_out,
  output logic                                 unk_out
);
  import psw_pkg::*;

  logic [CODE_W-1:0]             win_r;
  logic [CODE_W-1:0]             eval_r;
  logic signed [WEIGHT_BITS-1:0] weight_r [4];
  logic signed [SUM_W-1:0]       sum_r;
  logic                          unk_r;

  logic                          known;
  logic [COL_W-1:0]              col;
  logic signed [SUM_W-1:0]       term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.clear) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= base_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_r[wr_col] <= wr_val;
    end
    if (ctl.capture) begin
      eval_r <= win_r;
    end else if (ctl.align) begin
      eval_r <= eval_in;
    end
    sum_r <= sum_in + term;
    unk_r <= unk_in | (in_use & ~known);
  end

  // Codes other than A, C, G, T count as unknown.
  always_comb begin
    known = (eval_r >= CODE_A) && (eval_r <= CODE_T);
    col   = COL_W'(eval_r - CODE_A);
    if (in_use && known) begin
      term = SUM_W'(weight_r[col]);
    end else begin
      term = '0;
    end
  end

  assign base_out = win_r;
  assign eval_out = eval_r;
  assign sum_out  = sum_r;
  assign unk_out  = unk_r;

endmodule

/* verif/scan_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for pssm_window_scan: keeps its own weight table, base window and
// register copies, predicts every result word and compares it on the out_ side.
// Depends on psw_pkg only; it observes the ports and drives nothing into the block.
module scan_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [psw_pkg::CMD_W-1:0]          in_command,
  input  logic [psw_pkg::POS_W-1:0]          in_weight_position,
  input  logic [psw_pkg::COL_W-1:0]          in_weight_base,
  input  logic signed [psw_pkg::WIN_W-1:0]   in_weight_value,
  input  logic [psw_pkg::CODE_W-1:0]         in_base_code,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [psw_pkg::ADDR_W-1:0]         out_window_start,
  input  logic signed [psw_pkg::SCORE_W-1:0] out_window_score,
  input  logic                               out_is_hit,
  input  logic                               out_has_unknown,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psw_pkg::CFG_DAT_W-1:0]      cfg_data,
  output int                                 fail_count,
  output int                                 results_due
);
  import psw_pkg::*;

  localparam int DEPTH = MAX_MOTIF_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0]         start;
    logic signed [SCORE_W-1:0] score;
    logic                      hit;
    logic                      unknown;
  } window_result_t;

  logic signed [WIN_W-1:0]   weight_mem [DEPTH*4];
  logic [CODE_W-1:0]         window_bases [DEPTH];
  logic [ADDR_W-1:0]         bases_seen;
  int                        fill_level;
  logic [MLEN_W-1:0]         motif_len;
  logic signed [SCORE_W-1:0] threshold;
  logic [ADDR_W-1:0]         region_base;
  window_result_t            pending_windows[$];

  // Push one base into the window and, once the window is full, queue the
  // score of the window that now ends with it.
  task automatic shift_in_base(input logic [CODE_W-1:0] code);
    int             len;
    int             i;
    longint         sum;
    bit             unk;
    logic [CODE_W-1:0] sym;
    window_result_t r;
    for (i = DEPTH - 1; i > 0; i--) window_bases[i] = window_bases[i-1];
    window_bases[0] = code;
    bases_seen = bases_seen + 1;
    if (fill_level < DEPTH) fill_level++;
    len = (motif_len == 0) ? 1 : (motif_len > DEPTH) ? DEPTH : motif_len;
    if (fill_level >= len) begin
      sum = 0;
      unk = 1'b0;
      // Position 0 of the motif lines up with the oldest base of the window.
      for (i = 0; i < len && !unk; i++) begin
        sym = window_bases[len-1-i];
        if (sym < CODE_A || sym > CODE_T) unk = 1'b1;
        else sum += weight_mem[i*4 + (sym - CODE_A)];
      end
      if (unk) r.score = UNKNOWN_SCORE;
      else if (sum > SCORE_MAX) r.score = SCORE_W'(SCORE_MAX);
      else if (sum < SCORE_MIN) r.score = SCORE_W'(SCORE_MIN);
      else r.score = SCORE_W'(sum);
      r.start = region_base + bases_seen - len;
      r.hit = (r.score > threshold);
      r.unknown = unk;
      pending_windows.insert(pending_windows.size(), r);
    end
  endtask

  always @(posedge clk) begin : monitor
    window_result_t want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < DEPTH; i++) window_bases[i] = '0;
      bases_seen = '0;
      fill_level = 0;
      motif_len = 6'd1;
      threshold = '0;
      region_base = '0;
      pending_windows.delete();
      fail_count = 0;
      results_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_windows.size() == 0) begin
          $error("result word with nothing predicted: start %0h score %0d",
                 out_window_start, out_window_score);
          fail_count++;
        end else begin
          want = pending_windows.pop_front();
          if (out_window_start !== want.start) begin
            $error("window_start: expected %0h, got %0h", want.start, out_window_start);
            fail_count++;
          end
          if (out_window_score !== want.score) begin
            $error("window_score: expected %0d, got %0d", want.score, out_window_score);
            fail_count++;
          end
          if (out_is_hit !== want.hit) begin
            $error("is_hit: expected %0b, got %0b", want.hit, out_is_hit);
            fail_count++;
          end
          if (out_has_unknown !== want.unknown) begin
            $error("has_unknown: expected %0b, got %0b", want.unknown, out_has_unknown);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOTIF_LEN: motif_len = cfg_data[MLEN_W-1:0];
          REG_THRESHOLD: threshold = cfg_data[SCORE_W-1:0];
          REG_REGION:    region_base = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_LOAD: weight_mem[in_weight_position*4 + in_weight_base] = in_weight_value;
          CMD_REGION: begin
            for (i = 0; i < DEPTH; i++) window_bases[i] = '0;
            bases_seen = '0;
            fill_level = 0;
          end
          CMD_SCORE: shift_in_base(in_base_code);
          default: ;
        endcase
      end
      results_due <= pending_windows.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Top of the pssm_window_scan testbench: clock, reset, word traffic on the
// in_, out_ and cfg_ channels, and the verdict. Depends on psw_pkg, the block
// and scan_checker, which does all prediction and comparison.
module tb;
  import psw_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_IDLE = 2'd3;  // unused command code
  localparam logic [COL_W-1:0]  COL_A = 2'd0;
  localparam logic [COL_W-1:0]  COL_C = 2'd1;
  localparam logic [COL_W-1:0]  COL_T = 2'd3;
  localparam logic [CODE_W-1:0] BASE_C = 3'd2;
  localparam logic signed [WIN_W-1:0] WEIGHT_TOP    = 16'sh7FFF;
  localparam logic signed [WIN_W-1:0] WEIGHT_BOTTOM = 16'sh8000;

  localparam int SETTLE       = 2*MAX_MOTIF_DEF + 16;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 500;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_command = '0;
  logic [POS_W-1:0]          in_weight_position = '0;
  logic [COL_W-1:0]          in_weight_base = '0;
  logic signed [WIN_W-1:0]   in_weight_value = '0;
  logic [CODE_W-1:0]         in_base_code = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ADDR_W-1:0]         out_window_start;
  logic signed [SCORE_W-1:0] out_window_score;
  logic                      out_is_hit;
  logic                      out_has_unknown;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DAT_W-1:0]      cfg_data = '0;
  int                        fail_count;
  int                        results_due;

  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  int items_sent = 0;
  int sink_wait = 0;
  int cycle_count;

  always #10 clk = ~clk;

  pssm_window_scan dut (.*);
  scan_checker chk (.*);

  // Receiver: a random stall after every accepted result word, and a long
  // hold-off once so that the block backs up into its input.
  always @(posedge clk) begin : sink
    int stall;
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (out_ready && out_valid) begin
      stall = quiet ? 0 : $urandom_range(0, 17);
      out_ready <= (stall == 0);
      sink_wait <= stall;
    end else if (!out_ready) begin
      out_ready <= (sink_wait <= 1);
      sink_wait <= (sink_wait > 0) ? sink_wait - 1 : 0;
    end
  end

  initial begin : backpressure
    wait (items_sent >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [COL_W-1:0] col, input logic signed [WIN_W-1:0] value,
                           input logic [CODE_W-1:0] code);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_weight_position <= pos;
    in_weight_base <= col;
    in_weight_value <= value;
    in_base_code <= code;
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_IDLE) items_sent++;
  endtask

  // Fields that the command does not use carry random values.
  task automatic rand_word(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code);
    send_word(cmd, POS_W'($urandom), COL_W'($urandom), WIN_W'($urandom), code);
  endtask

  function automatic logic signed [WIN_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return WEIGHT_TOP;
      1: return WEIGHT_BOTTOM;
      default: return WIN_W'($urandom);
    endcase
  endfunction

  task automatic configure(input logic [MLEN_W-1:0] mlen, input int thresh,
                           input logic [ADDR_W-1:0] base);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MOTIF_LEN;
    cfg_data <= 32'(mlen);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_THRESHOLD;
    cfg_data <= thresh;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_REGION;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted word has come out, then give the block time
  // to finish any work that produces no result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly a new region followed by a run of bases, with the odd weight
  // reload, stray region word, unused command or unknown symbol mixed in.
  task automatic random_traffic(input int count, input int span, input bit extremes);
    int stop;
    int run;
    int k;
    bit same;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] sym;
    stop = items_sent + count;
    while (items_sent < stop) begin
      quiet <= ($urandom_range(0, 4) == 0);
      case (extremes ? 0 : $urandom_range(0, 9))
        8: send_word(CMD_LOAD, POS_W'($urandom), COL_W'($urandom), pick_weight(),
                     CODE_W'($urandom));
        9: rand_word($urandom_range(0, 1) ? CMD_IDLE : CMD_REGION, CODE_W'($urandom));
        default: begin
          rand_word(CMD_REGION, CODE_W'($urandom));
          run = $urandom_range(1, span + 12);
          same = extremes || ($urandom_range(0, 3) == 0);
          if (extremes) code = $urandom_range(0, 1) ? CODE_A : CODE_T;
          else code = CODE_W'($urandom_range(CODE_A, CODE_T));
          for (k = 0; k < run; k++) begin
            if (!same && $urandom_range(0, 2) == 0) begin
              code = CODE_W'($urandom_range(CODE_A, CODE_T));
            end
            sym = code;
            if (!extremes && $urandom_range(0, 39) == 0) begin
              do sym = CODE_W'($urandom); while (sym >= CODE_A && sym <= CODE_T);
            end
            rand_word(CMD_SCORE, sym);
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int pos;
    int col;
    int k;
    int phase;
    int mlen;
    int span;
    int thresh;
    int stop;
    bit extremes;
    logic [ADDR_W-1:0] base;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The whole table is written before any window is scored. Column A
    // holds the largest weight and column T the smallest, so that long runs of
    // one base reach the bottom of the score range and come close to its top.
    for (pos = 0; pos < MAX_MOTIF_DEF; pos++) begin
      for (col = 0; col < 4; col++) begin
        if (col == COL_A) begin
          send_word(CMD_LOAD, POS_W'(pos), COL_W'(col), WEIGHT_TOP, CODE_W'($urandom));
        end else if (col == COL_T) begin
          send_word(CMD_LOAD, POS_W'(pos), COL_W'(col), WEIGHT_BOTTOM, CODE_W'($urandom));
        end else begin
          send_word(CMD_LOAD, POS_W'(pos), COL_W'(col), pick_weight(), CODE_W'($urandom));
        end
      end
    end

    // One-base windows under the reset settings: every symbol code, where
    // codes outside the alphabet must give the unknown sentinel, then the unused
    // command, both weight extremes on one column and a fresh region.
    for (k = 0; k < 8; k++) rand_word(CMD_SCORE, CODE_W'(k));
    rand_word(CMD_IDLE, CODE_A);
    send_word(CMD_LOAD, '0, COL_C, WEIGHT_TOP, CODE_W'($urandom));
    rand_word(CMD_SCORE, BASE_C);
    send_word(CMD_LOAD, '0, COL_C, WEIGHT_BOTTOM, CODE_W'($urandom));
    rand_word(CMD_SCORE, BASE_C);
    rand_word(CMD_REGION, CODE_W'($urandom));
    rand_word(CMD_SCORE, CODE_A);

    stop = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < stop) begin
      drain();
      extremes = 1'b0;
      base = $urandom;
      case (phase)
        0: begin
          mlen = 0;  // behaves as a one-base window
          thresh = -1;
          base = '1;
        end
        1: begin
          mlen = MAX_MOTIF_DEF;
          thresh = SCORE_MAX;
          base = 32'hFFFF_FFF0;
          extremes = 1'b1;
        end
        2: begin
          mlen = MAX_MOTIF_DEF;
          thresh = SCORE_MIN;
          extremes = 1'b1;
        end
        3: mlen = 63;
        4: mlen = MAX_MOTIF_DEF + 1;
        default: mlen = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                             : $urandom_range(1, MAX_MOTIF_DEF);
      endcase
      span = (mlen == 0) ? 1 : (mlen > MAX_MOTIF_DEF) ? MAX_MOTIF_DEF : mlen;
      if (phase > 2) thresh = int'($urandom_range(0, span * 40000)) - span * 20000;
      configure(MLEN_W'(mlen), thresh, base);
      random_traffic(90, span, extremes);
      phase++;
    end

    quiet <= 1'b0;
    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
